[src/fcl_pkg.sv]
// Shared types, codes and constants of the per-client flood limiter.
package fcl_pkg;

	localparam int CLIENT_SLOTS_DEF = 1024;
	localparam int CLIENT_W         = 10;
	localparam int WEIGHT_W         = 12;
	localparam int LEVEL_W          = 16;
	localparam int FUNC_W           = 2;
	localparam int CFG_IDX_W        = 2;

	// Item function codes
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_MESSAGE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_TICK    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLOOD_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_THR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECLINE     = 2'd2;

	// Reset values of the configuration registers
	localparam logic [LEVEL_W-1:0] FLOOD_LIMIT_RST = 16'd1000;
	localparam logic [LEVEL_W-1:0] WARN_THR_RST    = 16'd500;
	localparam logic [LEVEL_W-1:0] DECLINE_RST     = 16'd100;

	typedef enum logic {
		ALU_ADD_SAT,
		ALU_SUB_CLAMP
	} alu_op_t;

	typedef struct packed {
		alu_op_t              op;
		logic [LEVEL_W-1:0]   a;
		logic [LEVEL_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   level;
		logic                 kick;
		logic                 warn;
	} alu_res_t;

endpackage

[src/fcl_mem.sv]
// Flood level table: one write port, one read port with registered read data.
module fcl_mem
	import fcl_pkg::*;
#(
	parameter int DEPTH = CLIENT_SLOTS_DEF,
	parameter int AW    = $clog2(CLIENT_SLOTS_DEF)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [LEVEL_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [LEVEL_W-1:0] rdata
);

	logic [LEVEL_W-1:0] mem_q [DEPTH];
	logic [LEVEL_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/fcl_alu.sv]
// Shared level unit: saturating add or clamped subtract, then limit compares.
module fcl_alu
	import fcl_pkg::*;
(
	input  alu_req_t           req,
	input  logic [LEVEL_W-1:0] flood_limit,
	input  logic [LEVEL_W-1:0] warn_threshold,
	output alu_res_t           res
);

	logic [LEVEL_W:0]   sum;
	logic [LEVEL_W-1:0] lvl;

	assign sum = {1'b0, req.a} + {1'b0, req.b};

	// select the level update
	always_comb begin
		case (req.op)
			ALU_ADD_SAT:   lvl = sum[LEVEL_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
			ALU_SUB_CLAMP: lvl = (req.a > req.b) ? (req.a - req.b) : '0;
			default:       lvl = '0;
		endcase
	end

	// threshold checks on the new level
	assign res.level = lvl;
	assign res.kick  = (lvl >= flood_limit);
	assign res.warn  = !(lvl >= flood_limit) && (lvl > warn_threshold);

endmodule

[src/per_client_flood_limiter_core.sv]
// Top level of the per-client flood limiter: sequencer, config and result register.
//
// Input channel s_*: one item per handshake, func in s_tuser, client and weight in
// s_tdata. Output channel m_*: exactly one result item per input item, in order.
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata), written idle.
//
// After reset the level table is cleared by a pass over all CLIENT_SLOTS entries,
// one entry per cycle; s_tready stays low until it is done.
// A message item reads its table entry on accept, then the shared level unit
// updates the entry and loads the result register. A clear item zeroes its entry
// on accept. A tick item walks the whole table through the same unit, one entry
// per cycle. Clear, tick, unused codes and slots out of range end in a zero result.
// The block handles one item at a time; s_tready is high only while it waits
// for an item.
// A finished result sits in the output register; if the receiver stalls, the
// next item is still accepted and processed, and it waits in its last step until
// the output register is free.
module per_client_flood_limiter_core
	import fcl_pkg::*;
#(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [LEVEL_W-1:0]   cfg_wdata,
	// input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // client[9:0], weight[21:10], zero[23:22]
	input  logic [FUNC_W-1:0]    s_tuser,   // func[1:0]
	// result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata    // client_out[9:0], kick[10], warn[11],
	                                        // level[27:12], zero[31:28]
);

	localparam int AW = $clog2(CLIENT_SLOTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CLIENT_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MSG,
		ST_TICK,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [LEVEL_W-1:0]  flood_limit_q;
	logic [LEVEL_W-1:0]  warn_thr_q;
	logic [LEVEL_W-1:0]  decline_q;

	logic [AW-1:0]       idx_q;
	logic [CLIENT_W-1:0] client_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [AW-1:0]       addr_q;

	logic                m_tvalid_q;
	logic [CLIENT_W-1:0] out_client_q;
	logic                out_kick_q;
	logic                out_warn_q;
	logic [LEVEL_W-1:0]  out_level_q;

	logic [FUNC_W-1:0]   in_func;
	logic [CLIENT_W-1:0] in_client;
	logic [WEIGHT_W-1:0] in_weight;
	logic [AW-1:0]       in_addr;
	logic                in_range;
	logic                accept;
	logic                out_free;
	logic                out_load;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [LEVEL_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [LEVEL_W-1:0]  mem_rdata;

	alu_req_t            alu_req;
	alu_res_t            alu_res;

	// input unpacking
	assign in_func   = s_tuser;
	assign in_client = s_tdata[CLIENT_W-1:0];
	assign in_weight = s_tdata[CLIENT_W+WEIGHT_W-1:CLIENT_W];
	assign in_addr   = AW'(in_client);
	assign in_range  = (32'(in_client) < CLIENT_SLOTS);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	// a finishing step loads the result register this cycle
	assign out_load = out_free && (state_q == ST_MSG || state_q == ST_FIN);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flood_limit_q <= FLOOD_LIMIT_RST;
			warn_thr_q    <= WARN_THR_RST;
			decline_q     <= DECLINE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FLOOD_LIMIT: flood_limit_q <= cfg_wdata;
				REG_WARN_THR:    warn_thr_q    <= cfg_wdata;
				REG_DECLINE:     decline_q     <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// shared unit operands
	always_comb begin
		alu_req.a = mem_rdata;
		if (state_q == ST_TICK) begin
			alu_req.op = ALU_SUB_CLAMP;
			alu_req.b  = decline_q;
		end else begin
			alu_req.op = ALU_ADD_SAT;
			alu_req.b  = LEVEL_W'(weight_q);
		end
	end

	fcl_alu u_alu (
		.req            (alu_req),
		.flood_limit    (flood_limit_q),
		.warn_threshold (warn_thr_q),
		.res            (alu_res)
	);

	// table port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = in_addr;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && in_range && in_func == FN_CLEAR) begin
					mem_we    = 1'b1;
					mem_waddr = in_addr;
				end
				if (accept && in_range && in_func == FN_MESSAGE) begin
					mem_re = 1'b1;
				end
				if (accept && in_func == FN_TICK) begin
					mem_re    = 1'b1;
					mem_raddr = '0;
				end
			end
			ST_MSG: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = addr_q;
					mem_wdata = alu_res.level;
				end
			end
			ST_TICK: begin
				mem_we    = 1'b1;
				mem_wdata = alu_res.level;
				if (idx_q != LAST_IDX) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	fcl_mem #(
		.DEPTH (CLIENT_SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			idx_q        <= '0;
			client_q     <= '0;
			weight_q     <= '0;
			addr_q       <= '0;
			m_tvalid_q   <= 1'b0;
			out_client_q <= '0;
			out_kick_q   <= 1'b0;
			out_warn_q   <= 1'b0;
			out_level_q  <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						weight_q <= in_weight;
						addr_q   <= in_addr;
						if (in_func == FN_TICK) begin
							client_q <= '0;
							state_q  <= ST_TICK;
						end else if (in_func != FN_CLEAR && in_func != FN_MESSAGE) begin
							client_q <= '0;
							state_q  <= ST_FIN;
						end else if (in_range && in_func == FN_MESSAGE) begin
							client_q <= in_client;
							state_q  <= ST_MSG;
						end else begin
							client_q <= in_client;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_MSG: begin
					if (out_free) begin
						out_client_q <= client_q;
						out_kick_q   <= alu_res.kick;
						out_warn_q   <= alu_res.warn;
						out_level_q  <= alu_res.level;
						state_q      <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_client_q <= client_q;
						out_kick_q   <= 1'b0;
						out_warn_q   <= 1'b0;
						out_level_q  <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output packing
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_level_q, out_warn_q, out_kick_q, out_client_q};

`ifndef SYNTHESIS
	// the sweep never reads and writes the same entry in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("table read and write hit the same entry");

	// a tick keeps the input side closed in the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_func == FN_TICK) |=> !s_tready)
		else $error("input ready during tick sweep");

	// a result appears only out of a finishing step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_MSG || $past(state_q) == ST_FIN))
		else $error("result produced outside a finishing step");

	// kick and warn are never raised together
	a_kick_warn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_kick_q && out_warn_q))
		else $error("kick and warn both set");
`endif

endmodule

[tb/sv/tb_per_client_flood_limiter_core.sv]
// Testbench of the per-client flood limiter: directed and random items, checked against a predictor.
`timescale 1ns / 100ps

module tb_per_client_flood_limiter_core;
	import fcl_pkg::*;

	localparam int SLOTS = CLIENT_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 305;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [CLIENT_W-1:0] client;
		logic [WEIGHT_W-1:0] weight;
	} fl_item_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] client;
		logic                kick;
		logic                warn;
		logic [LEVEL_W-1:0]  level;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [LEVEL_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;   // client[9:0], weight[21:10], zero[23:22]
	logic [FUNC_W-1:0]    s_tuser = '0;   // func[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;        // client_out[9:0], kick[10], warn[11], level[27:12]

	// predictor state: flood levels and the register copies
	logic [LEVEL_W-1:0] bucket [SLOTS] = '{default: '0};
	logic [LEVEL_W-1:0] cfg_limit = FLOOD_LIMIT_RST;
	logic [LEVEL_W-1:0] cfg_warn = WARN_THR_RST;
	logic [LEVEL_W-1:0] cfg_decline = DECLINE_RST;

	fl_item_t pending_q[$];
	verdict_t verdict_q[$];
	fl_item_t cur_item;
	int       gap_pct = 13;
	int       stall_pct = 47;
	int       errors = 0;
	int       cycle_cnt = 0;

	per_client_flood_limiter_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[per_client_flood_limiter_core] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_cnt, what);
		errors++;
	endtask

	// apply one item to the level table, return the result it causes
	function automatic verdict_t rate_item(input fl_item_t it);
		verdict_t v;
		logic [LEVEL_W:0] sum;
		v = '0;
		case (it.func)
			FN_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (bucket[i] > cfg_decline) bucket[i] = bucket[i] - cfg_decline;
					else bucket[i] = '0;
				end
			end
			FN_CLEAR, FN_MESSAGE: begin
				v.client = it.client;
				if (it.client < SLOTS) begin
					if (it.func == FN_CLEAR) begin
						bucket[it.client] = '0;
					end else begin
						sum = {1'b0, bucket[it.client]} + it.weight;
						if (sum[LEVEL_W]) sum = {1'b0, {LEVEL_W{1'b1}}};
						bucket[it.client] = sum[LEVEL_W-1:0];
						v.level = sum[LEVEL_W-1:0];
						v.kick = (v.level >= cfg_limit);
						v.warn = !v.kick && (v.level > cfg_warn);
					end
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// driver: predict on accept, then offer the next pending item or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) verdict_q.push_back(rate_item(cur_item));
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
					cur_item = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_item.weight, cur_item.client};
					s_tuser <= cur_item.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		verdict_t exp_v;
		if (m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				exp_v = verdict_q.pop_front();
				if (m_tdata[9:0] !== exp_v.client)
					report_mismatch($sformatf("client %0d, expected %0d",
						m_tdata[9:0], exp_v.client));
				if (m_tdata[10] !== exp_v.kick)
					report_mismatch($sformatf("kick %b, expected %b (client %0d)",
						m_tdata[10], exp_v.kick, exp_v.client));
				if (m_tdata[11] !== exp_v.warn)
					report_mismatch($sformatf("warn %b, expected %b (client %0d)",
						m_tdata[11], exp_v.warn, exp_v.client));
				if (m_tdata[27:12] !== exp_v.level)
					report_mismatch($sformatf("level %0d, expected %0d (client %0d)",
						m_tdata[27:12], exp_v.level, exp_v.client));
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic push_item(input logic [FUNC_W-1:0] f, input logic [CLIENT_W-1:0] c,
			input logic [WEIGHT_W-1:0] w);
		fl_item_t it;
		it.func = f;
		it.client = c;
		it.weight = w;
		pending_q.push_back(it);
	endtask

	// wait until every item is sent and every result is in; checked at the
	// falling edge so the driver and monitor updates of the rising edge are seen
	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FLOOD_LIMIT: cfg_limit = val;
			REG_WARN_THR:    cfg_warn = val;
			REG_DECLINE:     cfg_decline = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [LEVEL_W-1:0] lim, input logic [LEVEL_W-1:0] thr,
			input logic [LEVEL_W-1:0] dec);
		write_reg(REG_FLOOD_LIMIT, lim);
		write_reg(REG_WARN_THR, thr);
		write_reg(REG_DECLINE, dec);
	endtask

	// a few hot clients so levels build up, plus the index extremes
	function automatic logic [CLIENT_W-1:0] pick_client();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return 10'd341;
			3: return 10'd682;
			4: return 10'd17;
			default: return CLIENT_W'($urandom_range(SLOTS - 1));
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return WEIGHT_W'($urandom_range(63));
			4, 5: return WEIGHT_W'($urandom_range(4095));
			default: return WEIGHT_W'($urandom_range(600));
		endcase
	endfunction

	// one random sequence; counts every item but those with the unused code
	task automatic queue_burst(output int counted);
		int kind;
		int n;
		logic [CLIENT_W-1:0] c;
		kind = $urandom_range(99);
		c = pick_client();
		counted = 0;
		if (kind < 9) begin
			push_item(FN_TICK, CLIENT_W'($urandom_range(1023)),
				WEIGHT_W'($urandom_range(4095)));
			counted = 1;
		end else if (kind < 14) begin
			// unused code, answered by the block with a zero result
			push_item(FN_UNUSED, CLIENT_W'($urandom_range(1023)),
				WEIGHT_W'($urandom_range(4095)));
		end else if (kind < 23) begin
			// flood to saturation
			n = $urandom_range(20, 17);
			for (int i = 0; i < n; i++)
				push_item(FN_MESSAGE, c, WEIGHT_W'($urandom_range(4095, 3900)));
			counted = n;
		end else if (kind < 31) begin
			push_item(FN_CLEAR, c, WEIGHT_W'($urandom_range(4095)));
			counted = 1;
		end else begin
			// connect then chat, or chat on an existing slot
			if ($urandom_range(2) == 0) begin
				push_item(FN_CLEAR, c, '0);
				counted++;
			end
			n = $urandom_range(24, 1);
			for (int i = 0; i < n; i++) push_item(FN_MESSAGE, c, pick_weight());
			counted += n;
		end
	endtask

	task automatic run_random(input int quota);
		int done_cnt;
		int n;
		done_cnt = 0;
		while (done_cnt < quota) begin
			queue_burst(n);
			done_cnt += n;
		end
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part with the reset settings
		push_item(FN_MESSAGE, 10'd0, 12'd0);
		push_item(FN_MESSAGE, 10'd1023, 12'd4095);
		push_item(FN_MESSAGE, 10'd5, 12'd500);      // at warn threshold: quiet
		push_item(FN_MESSAGE, 10'd5, 12'd1);        // just above: warn
		push_item(FN_MESSAGE, 10'd5, 12'd498);
		push_item(FN_MESSAGE, 10'd5, 12'd1);        // reaches limit: kick
		push_item(FN_MESSAGE, 10'd5, 12'd0);        // kicked level stays
		push_item(FN_TICK, 10'd0, 12'd0);
		push_item(FN_MESSAGE, 10'd5, 12'd0);
		push_item(FN_CLEAR, 10'd5, 12'd0);
		push_item(FN_MESSAGE, 10'd5, 12'd0);
		push_item(FN_UNUSED, 10'd1023, 12'd4095);
		push_item(FN_MESSAGE, 10'd682, 12'd2730);
		push_item(FN_MESSAGE, 10'd341, 12'd1365);
		push_item(FN_CLEAR, 10'd1023, 12'd4095);
		push_item(FN_TICK, 10'd1023, 12'd4095);
		push_item(FN_MESSAGE, 10'd1023, 12'd0);
		drain();
		run_random(PHASE_ITEMS);

		// no decay, warn on any level above zero, kick only at saturation
		write_all(16'hFFFF, 16'h0000, 16'h0000);
		run_random(PHASE_ITEMS);

		// every message kicks, tick empties every slot
		gap_pct = 47;
		stall_pct = 13;
		write_all(16'h0000, 16'hFFFF, 16'hFFFF);
		run_random(PHASE_ITEMS);

		write_all(LEVEL_W'($urandom_range(20000, 1)), LEVEL_W'($urandom_range(12000)),
			LEVEL_W'($urandom_range(3000)));
		run_random(PHASE_ITEMS);

		gap_pct = 0;
		stall_pct = 0;
		write_all(LEVEL_W'($urandom_range(65535, 1)), LEVEL_W'($urandom_range(65535)),
			LEVEL_W'($urandom_range(65535)));
		run_random(PHASE_ITEMS);

		write_all(16'h0001, 16'h0000, 16'h0001);
		run_random(PHASE_ITEMS);

		if (verdict_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
		if (errors == 0) begin
			$display("[per_client_flood_limiter_core] OK");
		end else begin
			$display("[per_client_flood_limiter_core] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
src/fcl_pkg.sv
src/fcl_mem.sv
src/fcl_alu.sv
src/per_client_flood_limiter_core.sv
tb/sv/tb_per_client_flood_limiter_core.sv
